[sv/gfnl_pkg.sv]
// ----------------------------------------------------------------------------
// gfnl_pkg: shared types and constants
// Word formats, command and kind codes and sizes for the top-k neighbour list.
// ----------------------------------------------------------------------------
package gfnl_pkg;

    localparam int MAX_NEIGHBORS = 8;
    localparam int INDEX_BITS    = 20;
    localparam int GROUP_BITS    = 16;
    localparam int DIST_BITS     = 32;
    localparam int RANK_BITS     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_NEIGHBORS + 1);
    localparam int K_BITS        = 4;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_ADDR_BITS-1:0] REG_K_IN_USE = '0;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_OFFER  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_NEIGHBOR = 2'd1,
        KIND_EMPTY    = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]            command;
        logic [INDEX_BITS-1:0] target_index;
        logic [GROUP_BITS-1:0] target_group;
        logic [INDEX_BITS-1:0] candidate_index;
        logic [GROUP_BITS-1:0] candidate_group;
        logic [DIST_BITS-1:0]  distance;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            neighbor_rank;
        logic [19:0]           neighbor_index;
        logic [31:0]           neighbor_distance;
        logic [3:0]            kept_count;
        logic [31:0]           worst_distance;
        logic                  last;
    } t_out_word;

    // per-cell control from the list controller
    typedef struct packed {
        logic held;    // cell lies below the held count
        logic insert;  // an accepted candidate goes into the chain this cycle
    } t_cell_ctl;

endpackage

[sv/group_filtered_top_k_neighbor_list_top.sv]
// ----------------------------------------------------------------------------
// group_filtered_top_k_neighbor_list_top: group-filtered top-k neighbour list
// Keeps the k nearest accepted candidates of one query in a sorted cell chain.
// ----------------------------------------------------------------------------
// begin and offer words are taken only while idle with the output free; an
// offer's status word is in the output register on the next cycle, insertion
// done in one pass of the chain; finish first starts the readout, then gives
// one neighbour word per cycle while the output is not stalled (an empty list
// gives one empty word); reset clears the count, the query and the output
// valid, and sets k to 8; slot contents are left as they are
module group_filtered_top_k_neighbor_list_top
    import gfnl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [K_BITS-1:0]     r_k;
    logic [CNT_BITS-1:0]   r_held, n_held;
    logic [INDEX_BITS-1:0] r_qidx, n_qidx;
    logic [GROUP_BITS-1:0] r_qgrp, n_qgrp;
    logic [RANK_BITS-1:0]  r_rank, n_rank;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [DIST_BITS-1:0]  r_worst, n_worst;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic [CNT_BITS-1:0]   k_eff;
    logic [CNT_BITS-1:0]   k_m1;
    logic [CNT_BITS-1:0]   cnt;
    logic [CNT_BITS-1:0]   cnt_new;
    logic                  out_free;
    logic                  take;
    logic                  cand_ok;
    logic                  do_insert;
    logic [DIST_BITS-1:0]  worst_now;
    logic [DIST_BITS-1:0]  worst_new;

    logic [MAX_NEIGHBORS-1:0] ge;
    logic [DIST_BITS-1:0]     cell_dist  [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0]    cell_index [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]     cell_next  [MAX_NEIGHBORS];

    // effective k: zero acts as one, large values clamp
    always_comb begin
        if (r_k == '0) begin
            k_eff = CNT_BITS'(1);
        end else if (CNT_BITS'(r_k) > CNT_BITS'(MAX_NEIGHBORS)) begin
            k_eff = CNT_BITS'(MAX_NEIGHBORS);
        end else begin
            k_eff = CNT_BITS'(r_k);
        end
    end

    assign k_m1     = k_eff - CNT_BITS'(1);
    assign cnt      = (r_held < k_eff) ? r_held : k_eff;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign take     = i_in_valid && o_in_ready;

    assign cand_ok = !((i_in_data.candidate_index > r_qidx)
                       || (i_in_data.candidate_group == r_qgrp));
    assign do_insert = take && (t_cmd'(i_in_data.command) == CMD_OFFER) && cand_ok
                       && !ge[k_m1[RANK_BITS-1:0]];
    assign cnt_new   = (cand_ok && (cnt < k_eff)) ? cnt + CNT_BITS'(1) : cnt;
    assign worst_now = (cnt == k_eff) ? cell_dist[k_m1[RANK_BITS-1:0]] : '1;
    assign worst_new = (cnt_new == k_eff) ? cell_next[k_m1[RANK_BITS-1:0]] : '1;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NEIGHBORS; gi++) begin : g_cell
            t_cell_ctl ctl;
            logic                  left_ge;
            logic [DIST_BITS-1:0]  left_dist;
            logic [INDEX_BITS-1:0] left_index;

            assign ctl.held   = CNT_BITS'(gi) < cnt;
            assign ctl.insert = do_insert;

            if (gi == 0) begin : g_head
                assign left_ge    = 1'b1;
                assign left_dist  = i_in_data.distance;
                assign left_index = i_in_data.candidate_index;
            end else begin : g_body
                assign left_ge    = ge[gi-1];
                assign left_dist  = cell_dist[gi-1];
                assign left_index = cell_index[gi-1];
            end

            gfnl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_left_ge    (left_ge),
                .i_left_dist  (left_dist),
                .i_left_index (left_index),
                .i_dist       (i_in_data.distance),
                .i_index      (i_in_data.candidate_index),
                .o_ge         (ge[gi]),
                .o_dist       (cell_dist[gi]),
                .o_index      (cell_index[gi]),
                .o_next_dist  (cell_next[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_qidx      = r_qidx;
        n_qgrp      = r_qgrp;
        n_rank      = r_rank;
        n_cnt       = r_cnt;
        n_worst     = r_worst;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (t_cmd'(i_in_data.command))
                        CMD_BEGIN: begin
                            n_qidx = i_in_data.target_index;
                            n_qgrp = i_in_data.target_group;
                            n_held = '0;
                        end
                        CMD_OFFER: begin
                            n_held      = cnt_new;
                            n_out       = '0;
                            n_out.kind  = KIND_STATUS;
                            n_out.kept_count     = 4'(cnt_new);
                            n_out.worst_distance = 32'(worst_new);
                            n_out.last  = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        CMD_FINISH: begin
                            if (cnt == '0) begin
                                n_out       = '0;
                                n_out.kind  = KIND_EMPTY;
                                n_out.worst_distance = 32'(worst_now);
                                n_out.last  = 1'b1;
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_READ;
                                n_rank  = '0;
                                n_cnt   = cnt;
                                n_worst = worst_now;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out.kind              = KIND_NEIGHBOR;
                    n_out.neighbor_rank     = 3'(r_rank);
                    n_out.neighbor_index    = 20'(cell_index[r_rank]);
                    n_out.neighbor_distance = 32'(cell_dist[r_rank]);
                    n_out.kept_count        = 4'(r_cnt);
                    n_out.worst_distance    = 32'(r_worst);
                    n_out.last  = (CNT_BITS'(r_rank) + CNT_BITS'(1)) == r_cnt;
                    n_out_valid = 1'b1;
                    if (n_out.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rank = r_rank + RANK_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_qidx      <= '0;
            r_qgrp      <= '0;
            r_out_valid <= 1'b0;
            r_k         <= K_BITS'(MAX_NEIGHBORS);
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_qidx      <= n_qidx;
            r_qgrp      <= n_qgrp;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr == REG_K_IN_USE)) begin
                r_k <= pwdata[K_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank  <= n_rank;
        r_cnt   <= n_cnt;
        r_worst <= n_worst;
        r_out   <= n_out;
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr == REG_K_IN_USE) ? CFG_DATA_BITS'(r_k) : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/gfnl_cell.sv]
// ----------------------------------------------------------------------------
// gfnl_cell: one slot of the sorted neighbour chain
// Holds one entry, compares it with the candidate and either keeps it, takes
// the candidate or takes the entry of its left neighbour.
// ----------------------------------------------------------------------------
module gfnl_cell
    import gfnl_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_left_ge,
    input  logic [DIST_BITS-1:0]  i_left_dist,
    input  logic [INDEX_BITS-1:0] i_left_index,
    input  logic [DIST_BITS-1:0]  i_dist,
    input  logic [INDEX_BITS-1:0] i_index,
    output logic                  o_ge,
    output logic [DIST_BITS-1:0]  o_dist,
    output logic [INDEX_BITS-1:0] o_index,
    output logic [DIST_BITS-1:0]  o_next_dist
);

    logic [DIST_BITS-1:0]  r_dist;
    logic [INDEX_BITS-1:0] r_index;
    logic [DIST_BITS-1:0]  n_dist;
    logic [INDEX_BITS-1:0] n_index;

    // entry stays ahead of the candidate on equal distance
    assign o_ge = i_ctl.held && (r_dist <= i_dist);

    always_comb begin
        n_dist  = r_dist;
        n_index = r_index;
        if (i_ctl.insert && !o_ge) begin
            if (i_left_ge) begin
                n_dist  = i_dist;
                n_index = i_index;
            end else begin
                n_dist  = i_left_dist;
                n_index = i_left_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist  <= n_dist;
        r_index <= n_index;
    end

    assign o_dist      = r_dist;
    assign o_index     = r_index;
    assign o_next_dist = n_dist;

endmodule
